>>> design/interval_set_reserve_defines.svh
// Assertion macros for the interval_set_reserve checker.
// No dependencies; included by the checker file only.
`ifndef INTERVAL_SET_RESERVE_DEFINES_SVH
`define INTERVAL_SET_RESERVE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ISR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ISR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/isr_pkg.sv
// Shared types and constants for the interval_set_reserve block.
// No dependencies; imported by the controller, datapath, top level, checker and testbench.
package isr_pkg;

  localparam int LIMIT_W = 20;
  localparam int TOTAL_W = 20;
  localparam int USED_W  = 8;
  localparam int STAT_W  = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd100000;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_OVERLAP = 3'd1;
  localparam logic [STAT_W-1:0] ST_LIMIT   = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] ST_ORDER   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_WRNEW
  } isr_state_t;

  // Controller to datapath
  typedef struct packed {
    logic              load;
    logic              init_scan;
    logic              scan;
    logic              merge_wr;
    logic              shift_rm;
    logic              shift_ins;
    logic              shift_run;
    logic              new_wr;
    logic              finish;
    logic [STAT_W-1:0] code;
  } isr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic order_err;
    logic limit_err;
    logic empty;
    logic scan_done;
    logic overlap;
    logic join_l;
    logic join_r;
    logic full;
    logic shift_done;
  } isr_flags_t;

endpackage

>>> design/isr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module isr_ram #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/isr_ctrl.sv
// Request sequencer: check, scan, merge or shift, then report.
// Depends on isr_pkg.
module isr_ctrl
  import isr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  isr_flags_t flags,
  output isr_cmd_t   cmd,
  output logic       busy
);

  isr_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.code  = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (flags.order_err) begin
          cmd.finish = 1'b1;
          cmd.code   = ST_ORDER;
          state_nxt  = S_IDLE;
        end else if (flags.limit_err) begin
          cmd.finish = 1'b1;
          cmd.code   = ST_LIMIT;
          state_nxt  = S_IDLE;
        end else begin
          cmd.init_scan = 1'b1;
          state_nxt     = flags.empty ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (flags.scan_done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (flags.overlap) begin
          cmd.finish = 1'b1;
          cmd.code   = ST_OVERLAP;
          state_nxt  = S_IDLE;
        end else if (flags.join_l && flags.join_r) begin
          cmd.merge_wr = 1'b1;
          cmd.shift_rm = 1'b1;
          state_nxt    = S_SHIFT;
        end else if (flags.join_l || flags.join_r) begin
          cmd.merge_wr = 1'b1;
          cmd.finish   = 1'b1;
          state_nxt    = S_IDLE;
        end else if (flags.full) begin
          cmd.finish = 1'b1;
          cmd.code   = ST_FULL;
          state_nxt  = S_IDLE;
        end else begin
          cmd.shift_ins = 1'b1;
          state_nxt     = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift_run = 1'b1;
        if (flags.shift_done) begin
          if (flags.join_l) begin
            // bridge merge: removal done, report
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_WRNEW;
          end
        end
      end
      S_WRNEW: begin
        cmd.new_wr = 1'b1;
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> design/isr_datapath.sv
// Range table storage, scan and shift engine, totals and result register.
// Depends on isr_pkg and isr_ram.
module isr_datapath
  import isr_pkg::*;
#(
  parameter int TABLE_ENTRIES = 128,
  parameter int UNIT_BITS     = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  isr_cmd_t             cmd,
  output isr_flags_t           flags,
  input  logic                 in_mode,
  input  logic [UNIT_BITS-1:0] in_first_unit,
  input  logic [UNIT_BITS-1:0] in_last_unit,
  input  logic                 cfg_valid,
  input  logic [LIMIT_W-1:0]   cfg_total_limit,
  output logic                 out_valid,
  output logic [STAT_W-1:0]    out_status,
  output logic [TOTAL_W-1:0]   out_reserved_total,
  output logic [USED_W-1:0]    out_entries_used
);

  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int UW = UNIT_BITS;
  localparam int EW = 1 + 2 * UW;
  localparam int LW = UW + 1;
  localparam int SW = ((TOTAL_W > LW) ? TOTAL_W : LW) + 1;

  // Request, limit and totals
  logic          mode_r;
  logic [UW-1:0] lo_r, hi_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [CW-1:0]      count_r, count_nxt;

  // Scan and shift
  logic [CW-1:0] ptr_r, didx_r, pos_r;
  logic          pend_r, iss_r, dir_up_r;
  logic [EW-1:0] prev_r, right_r;
  logic          prev_ok_r, right_ok_r;

  // RAM ports
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata, rdata;

  logic [UW-1:0] rd_start;
  logic [UW-1:0] prev_start, prev_end, right_start, right_end;
  logic [LW-1:0] len;
  logic          found, scan_last, shift_last;

  isr_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ptr_r[AW-1:0]),
    .rdata (rdata)
  );

  assign rd_start    = rdata[2*UW-1:UW];
  assign prev_start  = prev_r[2*UW-1:UW];
  assign prev_end    = prev_r[UW-1:0];
  assign right_start = right_r[2*UW-1:UW];
  assign right_end   = right_r[UW-1:0];
  assign len         = LW'(hi_r) - LW'(lo_r) + LW'(1);

  // Scan tests on the entry just read
  assign found     = pend_r && (rd_start > lo_r);
  assign scan_last = pend_r && (didx_r == count_r - CW'(1));
  assign shift_last = dir_up_r ? (ptr_r == count_r - CW'(1)) : (ptr_r == pos_r);

  // Status to the controller
  always_comb begin
    flags.order_err  = (lo_r > hi_r);
    flags.limit_err  = (SW'(total_r) + SW'(len)) > SW'(limit_r);
    flags.empty      = (count_r == '0);
    flags.scan_done  = found || scan_last;
    flags.overlap    = (prev_ok_r && (prev_end >= lo_r)) ||
                       (right_ok_r && (right_start <= hi_r));
    flags.join_l     = prev_ok_r && ((LW'(prev_end) + LW'(1)) == LW'(lo_r));
    flags.join_r     = right_ok_r && (LW'(right_start) == (LW'(hi_r) + LW'(1)));
    flags.full       = (count_r == CW'(TABLE_ENTRIES));
    flags.shift_done = !iss_r && !pend_r;
  end

  // Write port: merge, new entry, or one shifted entry
  always_comb begin
    we    = 1'b0;
    waddr = pos_r[AW-1:0];
    wdata = {mode_r, lo_r, hi_r};
    if (cmd.merge_wr) begin
      we = 1'b1;
      if (flags.join_l) begin
        waddr = AW'(pos_r - CW'(1));
        wdata = {1'b1, prev_start, (flags.join_r ? right_end : hi_r)};
      end else begin
        wdata = {1'b1, lo_r, right_end};
      end
    end else if (cmd.new_wr) begin
      we = 1'b1;
    end else if (cmd.shift_run && pend_r) begin
      we    = 1'b1;
      waddr = dir_up_r ? AW'(didx_r - CW'(1)) : AW'(didx_r + CW'(1));
      wdata = rdata;
    end
  end

  // Totals after an accepted request
  always_comb begin
    total_nxt = total_r;
    count_nxt = count_r;
    if (cmd.finish && (cmd.code == ST_OK)) begin
      total_nxt = TOTAL_W'(SW'(total_r) + SW'(len));
      if (flags.join_l && flags.join_r) begin
        count_nxt = count_r - CW'(1);
      end else if (!flags.join_l && !flags.join_r) begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= LIMIT_RESET;
      total_r   <= '0;
      count_r   <= '0;
      pend_r    <= 1'b0;
      iss_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        limit_r <= cfg_total_limit;
      end
      total_r   <= total_nxt;
      count_r   <= count_nxt;
      out_valid <= cmd.finish;
      if (cmd.init_scan) begin
        pend_r <= 1'b0;
      end else if (cmd.scan) begin
        pend_r <= 1'b1;
      end else if (cmd.shift_rm) begin
        pend_r <= 1'b0;
        iss_r  <= (pos_r + CW'(1)) < count_r;
      end else if (cmd.shift_ins) begin
        pend_r <= 1'b0;
        iss_r  <= (count_r > pos_r);
      end else if (cmd.shift_run) begin
        pend_r <= iss_r;
        if (iss_r && shift_last) begin
          iss_r <= 1'b0;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      lo_r   <= in_first_unit;
      hi_r   <= in_mode ? in_last_unit : in_first_unit;
    end
    if (cmd.init_scan) begin
      ptr_r      <= '0;
      pos_r      <= '0;
      prev_ok_r  <= 1'b0;
      right_ok_r <= 1'b0;
    end
    if (cmd.scan) begin
      ptr_r  <= ptr_r + CW'(1);
      didx_r <= ptr_r;
      if (pend_r) begin
        if (found) begin
          right_r    <= rdata;
          right_ok_r <= 1'b1;
          pos_r      <= didx_r;
        end else begin
          prev_r    <= rdata;
          prev_ok_r <= 1'b1;
          if (scan_last) begin
            pos_r <= count_r;
          end
        end
      end
    end
    if (cmd.shift_rm) begin
      ptr_r    <= pos_r + CW'(1);
      dir_up_r <= 1'b1;
    end
    if (cmd.shift_ins) begin
      ptr_r    <= count_r - CW'(1);
      dir_up_r <= 1'b0;
    end
    if (cmd.shift_run && iss_r) begin
      didx_r <= ptr_r;
      ptr_r  <= dir_up_r ? (ptr_r + CW'(1)) : (ptr_r - CW'(1));
    end
    if (cmd.finish) begin
      out_status         <= cmd.code;
      out_reserved_total <= total_nxt;
      out_entries_used   <= USED_W'(count_nxt);
    end
  end

endmodule

>>> design/interval_set_reserve.sv
// Channel   Ports                                            Handshake
// request   in_mode, in_first_unit, in_last_unit             start && !busy
// result    out_status, out_reserved_total, out_entries_used out_valid, one-cycle strobe
// config    cfg_total_limit                                  cfg_valid && cfg_ready
//
// Accept to result strobe: a first-after-last or limit rejection ends at the check; an
// overlap, table-full rejection or in-place merge after the sorted scan; a bridging merge
// or insert after the scan and a shift (no scan when the table is empty), an insert then
// writing its new entry. n entries are read by the sorted scan, m entries moved, one per
// cycle through the table RAM. n + m never exceeds the entry count plus one.
// out_valid strobes in the first cycle with busy low; it cannot be stalled.
// Synchronous active-low reset empties the table (count and total zeroed) at once;
// the limit returns to 100000. cfg_ready is always high.
// Top level of the sorted interval reservation table; depends on isr_pkg,
// isr_ctrl, isr_datapath and isr_ram.
module interval_set_reserve
  import isr_pkg::*;
#(
  parameter int TABLE_ENTRIES = 128,
  parameter int UNIT_BITS     = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_mode,
  input  logic [UNIT_BITS-1:0] in_first_unit,
  input  logic [UNIT_BITS-1:0] in_last_unit,
  output logic                 out_valid,
  output logic [STAT_W-1:0]    out_status,
  output logic [TOTAL_W-1:0]   out_reserved_total,
  output logic [USED_W-1:0]    out_entries_used,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [LIMIT_W-1:0]   cfg_total_limit
);

  isr_cmd_t   cmd;
  isr_flags_t flags;

  assign cfg_ready = 1'b1;

  isr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .cmd   (cmd),
    .busy  (busy)
  );

  isr_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .UNIT_BITS     (UNIT_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .flags              (flags),
    .in_mode            (in_mode),
    .in_first_unit      (in_first_unit),
    .in_last_unit       (in_last_unit),
    .cfg_valid          (cfg_valid),
    .cfg_total_limit    (cfg_total_limit),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_reserved_total (out_reserved_total),
    .out_entries_used   (out_entries_used)
  );

endmodule

>>> design/isr_checker.sv
// Port-level checks for interval_set_reserve, bound to the top level.
// Depends on isr_pkg and interval_set_reserve_defines.svh.
`include "interval_set_reserve_defines.svh"

module isr_checker
  import isr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [STAT_W-1:0] out_status
);

  // An accepted request always occupies the block
  `ISR_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "not busy after transfer")

  // The result is reported once the block is free again
  `ISR_ASSERT_NOW(a_result_when_idle, out_valid, !busy, "result while busy")

  // One result per request; the result strobe is never held high
  `ISR_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe held")

  // Only defined status codes are reported (codes run from ST_OK to ST_ORDER)
  `ISR_ASSERT_NOW(a_status_code, out_valid, (out_status <= ST_ORDER), "bad status")

endmodule

bind interval_set_reserve isr_checker u_isr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_status (out_status)
);

>>> tb/sv/isr_result_checker.sv
// Result checker for interval_set_reserve: keeps its own copy of the range table and limit.
// It predicts every accepted request and compares each result strobe against it.
// Depends on isr_pkg.
`timescale 1ns / 100ps
module isr_result_checker
  import isr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_mode,
  input  logic [19:0]        in_first_unit,
  input  logic [19:0]        in_last_unit,
  input  logic               out_valid,
  input  logic [STAT_W-1:0]  out_status,
  input  logic [TOTAL_W-1:0] out_reserved_total,
  input  logic [USED_W-1:0]  out_entries_used,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_total_limit,
  output int                 errors,
  output int                 pending
);

  localparam int DEPTH = 128;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [TOTAL_W-1:0] total;
    logic [USED_W-1:0]  used;
  } reserve_result_t;

  // Shadow table
  bit              span_kind [DEPTH];
  bit [19:0]       span_lo   [DEPTH];
  bit [19:0]       span_hi   [DEPTH];
  int              span_count;
  longint          units_held;
  longint          units_cap;
  reserve_result_t awaited_results[$];

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Applies one request to the shadow table and returns the result it gives
  function automatic reserve_result_t reserve_units(bit mode, bit [19:0] first_u,
                                                    bit [19:0] last_u);
    reserve_result_t r;
    longint lo, hi, len;
    int pos, k;
    bit join_l, join_r;
    logic [STAT_W-1:0] st;
    lo = first_u;
    hi = mode ? last_u : first_u;
    pos = 0;
    st = ST_OK;
    if (lo > hi) begin
      st = ST_ORDER;
    end else begin
      len = hi - lo + 1;
      if (units_held + len > units_cap) begin
        st = ST_LIMIT;
      end else begin
        while (pos < span_count && span_lo[pos] <= lo) pos++;
        if ((pos > 0 && span_hi[pos-1] >= lo) || (pos < span_count && span_lo[pos] <= hi)) begin
          st = ST_OVERLAP;
        end else begin
          // adjacency is tested without wrap
          join_l = (pos > 0) && (longint'(span_hi[pos-1]) + 1 == lo);
          join_r = (pos < span_count) && (longint'(span_lo[pos]) == hi + 1);
          if (join_l && join_r) begin
            span_hi[pos-1] = span_hi[pos];
            span_kind[pos-1] = 1'b1;
            for (k = pos; k + 1 < span_count; k++) begin
              span_kind[k] = span_kind[k+1];
              span_lo[k] = span_lo[k+1];
              span_hi[k] = span_hi[k+1];
            end
            span_count--;
          end else if (join_l) begin
            span_hi[pos-1] = hi[19:0];
            span_kind[pos-1] = 1'b1;
          end else if (join_r) begin
            span_lo[pos] = lo[19:0];
            span_kind[pos] = 1'b1;
          end else if (span_count >= DEPTH) begin
            st = ST_FULL;
          end else begin
            for (k = span_count; k > pos; k--) begin
              span_kind[k] = span_kind[k-1];
              span_lo[k] = span_lo[k-1];
              span_hi[k] = span_hi[k-1];
            end
            span_kind[pos] = mode;
            span_lo[pos] = lo[19:0];
            span_hi[pos] = hi[19:0];
            span_count++;
          end
          if (st == ST_OK) units_held += len;
        end
      end
    end
    r.status = st;
    r.total = units_held[TOTAL_W-1:0];
    r.used = span_count[USED_W-1:0];
    return r;
  endfunction

  // Compare first, then take config and request transfers of the same edge
  always @(posedge clk) begin
    reserve_result_t want;
    if (!rst_n) begin
      span_count = 0;
      units_held = 0;
      units_cap = LIMIT_RESET;
      awaited_results.delete();
      errors = 0;
    end else begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result, status", out_status, -1);
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_reserved_total !== want.total)
            report_mismatch("reserved_total", out_reserved_total, want.total);
          if (out_entries_used !== want.used)
            report_mismatch("entries_used", out_entries_used, want.used);
        end
      end
      if (cfg_valid && cfg_ready) units_cap = cfg_total_limit;
      if (start && !busy)
        awaited_results.push_back(reserve_units(in_mode, in_first_unit, in_last_unit));
    end
    pending <= awaited_results.size();
  end

endmodule

>>> tb/sv/tb_interval_set_reserve.sv
// Testbench top for interval_set_reserve: clock, reset, request and limit stimulus, verdict.
// Depends on isr_pkg, interval_set_reserve and isr_result_checker.
`timescale 1ns / 100ps
module tb_interval_set_reserve;
  import isr_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_mode = 1'b0;
  logic [19:0]        in_first_unit = '0;
  logic [19:0]        in_last_unit = '0;
  logic               out_valid;
  logic [STAT_W-1:0]  out_status;
  logic [TOTAL_W-1:0] out_reserved_total;
  logic [USED_W-1:0]  out_entries_used;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_total_limit = '0;
  int                 errors;
  int                 pending;
  int                 idle_pct = 0;
  int                 quiet_cycles = 0;
  bit [19:0]          window;

  always #5 clk = ~clk;

  interval_set_reserve dut (.*);

  isr_result_checker checker_i (.*);

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One request transfer; entered and left just after a rising edge
  task automatic send_request(bit mode, bit [19:0] first_u, bit [19:0] last_u);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_first_unit <= first_u;
    in_last_unit <= last_u;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  // Let every result arrive, then hold off a little longer
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(bit [19:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_total_limit <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly short requests near a window so that overlaps and merges occur
  task automatic random_request();
    int pick;
    bit [19:0] f, l;
    pick = $urandom_range(99);
    f = 20'(window + $urandom_range(0, 400));
    l = 20'(f + $urandom_range(0, 3));
    if (pick < 10) begin
      f = 20'($urandom);
      l = 20'($urandom);
    end else if (pick < 18) begin
      l = 20'(f - $urandom_range(1, 5));
    end
    send_request(1'($urandom_range(1)), f, l);
  endtask

  initial begin
    int phase, n, k;
    bit [19:0] caps[6];
    caps = '{20'hFFFFF, 20'd0, 20'd3000, 20'd0, 20'd100000, 20'hFFFFF};
    caps[3] = 20'($urandom);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: new entries, overlap, ordering, limit and merges either side
    send_request(1'b0, 20'd10, 20'd0);
    send_request(1'b0, 20'd10, 20'd0);
    send_request(1'b1, 20'd20, 20'd15);
    send_request(1'b1, 20'd11, 20'd19);
    send_request(1'b1, 20'd22, 20'd30);
    send_request(1'b0, 20'd21, 20'hFFFFF);
    send_request(1'b0, 20'd9, 20'd3);
    send_request(1'b1, 20'd40, 20'd40);
    send_request(1'b1, 20'd5, 20'd12);
    send_request(1'b1, 20'hFFFFF, 20'hFFFFF);
    send_request(1'b1, 20'hFFFFE, 20'hFFFFE);
    send_request(1'b1, 20'd0, 20'hFFFFF);
    send_request(1'b1, 20'd100, 20'd100099);
    send_request(1'b1, 20'd100, 20'd99944);
    send_request(1'b0, 20'd0, 20'hFFFFF);
    send_request(1'b1, 20'hFFFFF, 20'd0);

    // Random phases, each under a limit from a list and one of three idling levels
    for (phase = 0; phase < 6; phase++) begin
      write_limit(caps[phase]);
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 77;
        2: idle_pct = 0;
        default: idle_pct = 30;
      endcase
      window = 20'($urandom_range(0, 20'hFFA00));
      for (n = 0; n < 200; n++) begin
        if (n % 50 == 49) window = 20'($urandom_range(0, 20'hFFA00));
        random_request();
      end
    end

    // Fill the table with spaced points until it overflows, then merge into it
    idle_pct = 0;
    window = 20'($urandom_range(0, 20'hFF000));
    for (k = 0; k < 140; k++) send_request(1'b0, 20'(window + 2 * k), 20'd0);
    for (k = 0; k < 20; k++) send_request(1'b0, 20'(window + 2 * k + 1), 20'd0);

    drain_results();
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
